// ----- design/tsm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsm_pkg: shared types of the two-way sorted merge
// Command codes, controller states and the command/status bundles that
// join the controller and the datapath.
// ----------------------------------------------------------------------------
package tsm_pkg;

   localparam int VALUE_W = 32;
   localparam int CMD_W   = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH_FIRST  = 2'd0,
      CMD_PUSH_SECOND = 2'd1,
      CMD_END_FIRST   = 2'd2,
      CMD_END_SECOND  = 2'd3
   } command_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_EMIT,
      ST_OVF
   } state_type;

   typedef struct packed {
      logic accept;
      logic emit;
      logic load_ovf;
      logic clear;
   } ctrl_cmd_type;

   typedef struct packed {
      logic can_emit;
      logic closed;
      logic ovf_pend;
      logic out_free;
      logic emit_last;
   } ctrl_status_type;

endpackage

// ----- design/tsm_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsm_req_if: command channel of the two-way sorted merge
// Valid/ready channel carrying one command and its value per transaction.
// ----------------------------------------------------------------------------
interface tsm_req_if;
   logic                              valid;
   logic                              ready;
   logic [tsm_pkg::CMD_W-1:0]         command;
   logic signed [tsm_pkg::VALUE_W-1:0] value;

   modport source (output valid, output command, output value, input ready);
   modport sink   (input valid, input command, input value, output ready);
endinterface

// ----- design/tsm_rsp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsm_rsp_if: result channel of the two-way sorted merge
// Valid/ready channel carrying one merged element and its flags per transaction.
// ----------------------------------------------------------------------------
interface tsm_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [tsm_pkg::VALUE_W-1:0] value_res;
   logic                               from_second;
   logic                               final_item;
   logic                               last_of_run;
   logic                               overflow;

   modport source (output valid, output value_res, output from_second,
                   output final_item, output last_of_run, output overflow,
                   input ready);
   modport sink   (input valid, input value_res, input from_second,
                   input final_item, input last_of_run, input overflow,
                   output ready);
endinterface

// ----- design/tsm_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsm_ctrl: merge controller
// Sequences command intake, head reads, element emission and overflow reports.
// ----------------------------------------------------------------------------
module tsm_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  tsm_pkg::ctrl_status_type status,
   output tsm_pkg::ctrl_cmd_type    cmd
);

   tsm_pkg::state_type state_ff;
   tsm_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tsm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tsm_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = tsm_pkg::ST_READ;
            end
         end
         tsm_pkg::ST_READ: begin
            priority if (status.ovf_pend) begin
               state_in = tsm_pkg::ST_OVF;
            end else if (status.can_emit) begin
               state_in = tsm_pkg::ST_EMIT;
            end else begin
               state_in = tsm_pkg::ST_IDLE;
            end
         end
         tsm_pkg::ST_EMIT: begin
            if (status.out_free) begin
               state_in = status.emit_last ? tsm_pkg::ST_IDLE : tsm_pkg::ST_READ;
            end
         end
         tsm_pkg::ST_OVF: begin
            if (status.out_free) begin
               state_in = tsm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tsm_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready    = 1'b0;
      cmd.accept   = 1'b0;
      cmd.emit     = 1'b0;
      cmd.load_ovf = 1'b0;
      cmd.clear    = 1'b0;
      unique case (state_ff)
         tsm_pkg::ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         tsm_pkg::ST_READ: begin
            cmd.clear = !status.ovf_pend && !status.can_emit && status.closed;
         end
         tsm_pkg::ST_EMIT: begin
            cmd.emit = status.out_free;
         end
         tsm_pkg::ST_OVF: begin
            cmd.load_ovf = status.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

// ----- design/tsm_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsm_datapath: merge datapath
// Two ring FIFOs with registered head reads, list state, head compare and
// the output register of the result channel.
// ----------------------------------------------------------------------------
module tsm_datapath #(
   parameter int QUEUE_DEPTH = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  tsm_pkg::ctrl_cmd_type              cmd,
   output tsm_pkg::ctrl_status_type           status,
   input  logic [tsm_pkg::CMD_W-1:0]          req_command,
   input  logic signed [tsm_pkg::VALUE_W-1:0] req_value,
   input  logic                               rsp_ready,
   output logic                               rsp_valid,
   output logic signed [tsm_pkg::VALUE_W-1:0] rsp_value_res,
   output logic                               rsp_from_second,
   output logic                               rsp_final_item,
   output logic                               rsp_last_of_run,
   output logic                               rsp_overflow
);

   localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(QUEUE_DEPTH);
   localparam logic [FILL_W-1:0] FILL_ONE  = FILL_W'(1);

   function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] ptr);
      ring_next = (ptr == PTR_LAST) ? '0 : ptr + PTR_W'(1);
   endfunction

   logic [tsm_pkg::VALUE_W-1:0] first_mem  [QUEUE_DEPTH];
   logic [tsm_pkg::VALUE_W-1:0] second_mem [QUEUE_DEPTH];

   logic [tsm_pkg::VALUE_W-1:0] first_rd_ff, second_rd_ff;

   logic [PTR_W-1:0]  first_head_ff,  first_head_in;
   logic [PTR_W-1:0]  first_tail_ff,  first_tail_in;
   logic [FILL_W-1:0] first_fill_ff,  first_fill_in;
   logic [PTR_W-1:0]  second_head_ff, second_head_in;
   logic [PTR_W-1:0]  second_tail_ff, second_tail_in;
   logic [FILL_W-1:0] second_fill_ff, second_fill_in;
   logic              first_ended_ff, first_ended_in;
   logic              second_ended_ff, second_ended_in;
   logic              ovf_pend_ff, ovf_pend_in;
   logic              ovf_second_ff, ovf_second_in;

   logic                        out_valid_ff, out_valid_in;
   logic [tsm_pkg::VALUE_W-1:0] out_value_ff, out_value_in;
   logic                        out_second_ff, out_second_in;
   logic                        out_final_ff, out_final_in;
   logic                        out_last_ff, out_last_in;
   logic                        out_ovf_ff, out_ovf_in;

   tsm_pkg::command_type cmd_code;
   logic push_first, push_second, wr_first, wr_second;
   logic first_full, second_full;
   logic have_first, have_second, have_both;
   logic take_second;
   logic [FILL_W-1:0] first_fill_pop, second_fill_pop;
   logic have_first_pop, have_second_pop;
   logic emit_final, emit_last, clear_all, out_free;

   assign cmd_code    = tsm_pkg::command_type'(req_command);
   assign first_full  = (first_fill_ff == FILL_FULL);
   assign second_full = (second_fill_ff == FILL_FULL);
   assign push_first  = cmd.accept && (cmd_code == tsm_pkg::CMD_PUSH_FIRST) && !first_ended_ff;
   assign push_second = cmd.accept && (cmd_code == tsm_pkg::CMD_PUSH_SECOND)
                        && !second_ended_ff;
   assign wr_first    = push_first && !first_full;
   assign wr_second   = push_second && !second_full;

   assign have_first  = (first_fill_ff != '0);
   assign have_second = (second_fill_ff != '0);
   assign have_both   = have_first && have_second;
   assign take_second = have_both ? ($signed(first_rd_ff) > $signed(second_rd_ff))
                                  : !have_first;

   assign first_fill_pop  = take_second ? first_fill_ff : first_fill_ff - FILL_ONE;
   assign second_fill_pop = take_second ? second_fill_ff - FILL_ONE : second_fill_ff;
   assign have_first_pop  = (first_fill_pop != '0);
   assign have_second_pop = (second_fill_pop != '0);
   assign emit_final = first_ended_ff && second_ended_ff && !have_first_pop && !have_second_pop;
   assign emit_last  = !((have_first_pop && have_second_pop)
                         || (have_first_pop && second_ended_ff)
                         || (have_second_pop && first_ended_ff));
   assign clear_all  = cmd.clear || (cmd.emit && emit_final);
   assign out_free   = !out_valid_ff || rsp_ready;

   assign status.can_emit  = have_both || (have_first && second_ended_ff)
                             || (have_second && first_ended_ff);
   assign status.closed    = first_ended_ff && second_ended_ff && !have_first && !have_second;
   assign status.ovf_pend  = ovf_pend_ff;
   assign status.out_free  = out_free;
   assign status.emit_last = emit_last;

   always_comb begin
      first_head_in   = first_head_ff;
      first_tail_in   = first_tail_ff;
      first_fill_in   = first_fill_ff;
      second_head_in  = second_head_ff;
      second_tail_in  = second_tail_ff;
      second_fill_in  = second_fill_ff;
      first_ended_in  = first_ended_ff;
      second_ended_in = second_ended_ff;
      ovf_pend_in     = ovf_pend_ff;
      ovf_second_in   = ovf_second_ff;

      if (wr_first) begin
         first_tail_in = ring_next(first_tail_ff);
         first_fill_in = first_fill_ff + FILL_ONE;
      end
      if (wr_second) begin
         second_tail_in = ring_next(second_tail_ff);
         second_fill_in = second_fill_ff + FILL_ONE;
      end
      if (cmd.accept && (cmd_code == tsm_pkg::CMD_END_FIRST)) begin
         first_ended_in = 1'b1;
      end
      if (cmd.accept && (cmd_code == tsm_pkg::CMD_END_SECOND)) begin
         second_ended_in = 1'b1;
      end
      if ((push_first && first_full) || (push_second && second_full)) begin
         ovf_pend_in   = 1'b1;
         ovf_second_in = push_second;
      end
      if (cmd.load_ovf) begin
         ovf_pend_in = 1'b0;
      end

      if (cmd.emit) begin
         if (take_second) begin
            second_head_in = ring_next(second_head_ff);
         end else begin
            first_head_in = ring_next(first_head_ff);
         end
         first_fill_in  = first_fill_pop;
         second_fill_in = second_fill_pop;
      end

      if (clear_all) begin
         first_head_in   = '0;
         first_tail_in   = '0;
         first_fill_in   = '0;
         second_head_in  = '0;
         second_tail_in  = '0;
         second_fill_in  = '0;
         first_ended_in  = 1'b0;
         second_ended_in = 1'b0;
      end
   end

   always_comb begin
      out_value_in  = out_value_ff;
      out_second_in = out_second_ff;
      out_final_in  = out_final_ff;
      out_last_in   = out_last_ff;
      out_ovf_in    = out_ovf_ff;
      priority if (cmd.emit) begin
         out_valid_in  = 1'b1;
         out_value_in  = take_second ? second_rd_ff : first_rd_ff;
         out_second_in = take_second;
         out_final_in  = emit_final;
         out_last_in   = emit_last;
         out_ovf_in    = 1'b0;
      end else if (cmd.load_ovf) begin
         out_valid_in  = 1'b1;
         out_value_in  = '0;
         out_second_in = ovf_second_ff;
         out_final_in  = 1'b0;
         out_last_in   = 1'b1;
         out_ovf_in    = 1'b1;
      end else begin
         out_valid_in  = out_valid_ff && !rsp_ready;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_first) begin
         first_mem[first_tail_ff] <= req_value;
      end
      if (wr_second) begin
         second_mem[second_tail_ff] <= req_value;
      end
      first_rd_ff  <= first_mem[first_head_ff];
      second_rd_ff <= second_mem[second_head_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_head_ff   <= '0;
         first_tail_ff   <= '0;
         first_fill_ff   <= '0;
         second_head_ff  <= '0;
         second_tail_ff  <= '0;
         second_fill_ff  <= '0;
         first_ended_ff  <= 1'b0;
         second_ended_ff <= 1'b0;
         ovf_pend_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
      end else begin
         first_head_ff   <= first_head_in;
         first_tail_ff   <= first_tail_in;
         first_fill_ff   <= first_fill_in;
         second_head_ff  <= second_head_in;
         second_tail_ff  <= second_tail_in;
         second_fill_ff  <= second_fill_in;
         first_ended_ff  <= first_ended_in;
         second_ended_ff <= second_ended_in;
         ovf_pend_ff     <= ovf_pend_in;
         out_valid_ff    <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ovf_second_ff <= ovf_second_in;
      out_value_ff  <= out_value_in;
      out_second_ff <= out_second_in;
      out_final_ff  <= out_final_in;
      out_last_ff   <= out_last_in;
      out_ovf_ff    <= out_ovf_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_value_res   = out_value_ff;
   assign rsp_from_second = out_second_ff;
   assign rsp_final_item  = out_final_ff;
   assign rsp_last_of_run = out_last_ff;
   assign rsp_overflow    = out_ovf_ff;

endmodule

// ----- design/two_way_sorted_merge.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_way_sorted_merge: merge of two ascending lists of signed 32-bit values
// req carries commands: push to list one or two, or end either list. Each
// accepted transaction causes zero or more results on rsp, the smaller head
// first and list one first on a tie; the last result of a transaction has
// last_of_run set, the last element of a merged pair has final_item set.
// A push into a full FIFO is dropped and reported by one overflow result.
// The first result of a transaction is loaded into the output register
// in state EMIT, which follows state READ after acceptance; each further
// result passes through READ and EMIT again, since the FIFO memories have
// a registered read port that feeds the head compare.
// req.ready is high only while no transaction is in progress.
// rsp is driven from an output register: when the receiver stalls, the
// result holds and emission pauses; a new command is still accepted while
// the last result of the previous one waits to be taken.
// Reset (synchronous) empties both FIFOs, clears the ended flags and drops
// any pending result; no clearing pass follows.
// ----------------------------------------------------------------------------
module two_way_sorted_merge #(
   parameter int QUEUE_DEPTH = 32
) (
   input  logic     clock,
   input  logic     reset,
   tsm_req_if.sink  req,
   tsm_rsp_if.source rsp
);

   tsm_pkg::ctrl_cmd_type    cmd;
   tsm_pkg::ctrl_status_type status;

   tsm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .status    (status),
      .cmd       (cmd)
   );

   tsm_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_command     (req.command),
      .req_value       (req.value),
      .rsp_ready       (rsp.ready),
      .rsp_valid       (rsp.valid),
      .rsp_value_res   (rsp.value_res),
      .rsp_from_second (rsp.from_second),
      .rsp_final_item  (rsp.final_item),
      .rsp_last_of_run (rsp.last_of_run),
      .rsp_overflow    (rsp.overflow)
   );

endmodule

// ----- design/tsm_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsm_checker: port-level checks of the two-way sorted merge
// Watches the req and rsp channels; attached to the top level by bind.
// ----------------------------------------------------------------------------
module tsm_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [tsm_pkg::VALUE_W-1:0] rsp_value_res,
   input logic                        rsp_final_item,
   input logic                        rsp_last_of_run,
   input logic                        rsp_overflow
);

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("command taken while previous transaction still in progress");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_overflow) |->
         (rsp_value_res == '0) && rsp_last_of_run && !rsp_final_item)
      else $error("malformed overflow result");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_final_item) |-> rsp_last_of_run)
      else $error("final element not marked last of run");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_value_res))
      else $error("stalled result changed");

endmodule

bind two_way_sorted_merge tsm_checker u_tsm_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req.valid),
   .req_ready       (req.ready),
   .rsp_valid       (rsp.valid),
   .rsp_ready       (rsp.ready),
   .rsp_value_res   (rsp.value_res),
   .rsp_final_item  (rsp.final_item),
   .rsp_last_of_run (rsp.last_of_run),
   .rsp_overflow    (rsp.overflow)
);
